@@ rtl/core/skvt_pkg.sv @@
// Package for the sorted key/value table: sizes, the command and result
// transfer types, the status codes and the token that travels along the cells.
// Depends on nothing.
package skvt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_LOOKUP   = 2'd0,
		ST_UPDATED  = 2'd1,
		ST_INSERTED = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_LOOKUP = 1'b0,
		MODE_UPSERT = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] value_out;
		status_t               status;
		logic [COUNT_W-1:0]    entry_count;
	} result_t;

	typedef struct packed {
		logic                  act;
		mode_t                 mode;
		logic                  full;
		logic                  pending;
		logic                  found;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [VALUE_BITS-1:0] rdval;
	} tok_t;

endpackage

@@ rtl/core/sorted_key_value_table.sv @@
// Sorted key/value table built as a chain of TABLE_DEPTH cells.
// The accepted command is registered at the entry, in every cell of the chain and in the done register before done.
// A new command is taken only while not busy; busy stays high until the token has left the chain.
// Reset empties the table at once; the entries themselves are not cleared.
// The receiver cannot stall: each result is valid only while done is high.
module sorted_key_value_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  skvt_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done,
	output skvt_pkg::result_t result
);
	import skvt_pkg::*;

	tok_t               tok [TABLE_DEPTH+1];
	tok_t               entry_q;
	logic               busy_q;
	logic               done_q;
	result_t            result_q;
	logic [COUNT_W-1:0] used_q;
	logic               accept;
	tok_t               last;
	logic               inserted;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.act <= 1'b0;
		end else begin
			entry_q.act     <= accept;
			entry_q.mode    <= cmd.mode;
			entry_q.full    <= (used_q == COUNT_W'(TABLE_DEPTH));
			entry_q.pending <= 1'b1;
			entry_q.found   <= 1'b0;
			entry_q.key     <= cmd.key;
			entry_q.value   <= cmd.value;
			entry_q.rdval   <= '0;
		end
	end

	assign tok[0] = entry_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		skvt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.used   (used_q),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign last     = tok[TABLE_DEPTH];
	assign inserted = (last.mode == MODE_UPSERT) && !last.found && !last.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			used_q <= '0;
		end else begin
			done_q <= last.act;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.act) begin
				busy_q <= 1'b0;
			end
			if (last.act && inserted) begin
				used_q <= used_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.act) begin
			result_q.found     <= last.found;
			result_q.value_out <= last.rdval;
			if (last.mode == MODE_LOOKUP) begin
				result_q.status <= ST_LOOKUP;
			end else if (last.found) begin
				result_q.status <= ST_UPDATED;
			end else if (last.full) begin
				result_q.status <= ST_DROPPED;
			end else begin
				result_q.status <= ST_INSERTED;
			end
			result_q.entry_count <= inserted ? used_q + COUNT_W'(1) : used_q;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	a_done_not_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while an item is still in the chain");

	a_accept_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted without raising busy");

	a_count_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= COUNT_W'(TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	a_drop_full : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DROPPED) |->
		(result.entry_count == COUNT_W'(TABLE_DEPTH)))
		else $error("item dropped while the table had room");

endmodule

@@ rtl/core/skvt_cell.sv @@
// One cell of the table: holds a single key/value entry and passes the
// travelling token on to its neighbour through a register, in the next cycle.
// Depends on skvt_pkg.
module skvt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [skvt_pkg::IDX_W-1:0]   idx,
	input  logic [skvt_pkg::COUNT_W-1:0] used,
	input  skvt_pkg::tok_t             tok_in,
	output skvt_pkg::tok_t             tok_out
);
	import skvt_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  occupied;
	logic                  at_end;
	logic                  eq;
	logic                  gt;
	logic                  wr;
	logic [KEY_BITS-1:0]   wkey;
	logic [VALUE_BITS-1:0] wval;
	tok_t                  tok_d;

	assign occupied = ({1'b0, idx} < used);
	assign at_end   = ({1'b0, idx} == used);
	assign eq       = occupied && (key_q == tok_in.key);
	assign gt       = occupied && (key_q > tok_in.key);

	// A new pair displaces every larger entry, which then travels on in the
	// token until it lands in the first empty cell.
	always_comb begin
		tok_d = tok_in;
		wr    = 1'b0;
		wkey  = tok_in.key;
		wval  = tok_in.value;
		if (tok_in.act) begin
			if (tok_in.mode == MODE_LOOKUP) begin
				if (eq) begin
					tok_d.found = 1'b1;
					tok_d.rdval = val_q;
				end
			end else if (tok_in.pending) begin
				if (eq) begin
					wr            = 1'b1;
					wkey          = key_q;
					tok_d.found   = 1'b1;
					tok_d.pending = 1'b0;
				end else if (!tok_in.full) begin
					if (gt) begin
						wr          = 1'b1;
						tok_d.key   = key_q;
						tok_d.value = val_q;
					end else if (at_end) begin
						wr            = 1'b1;
						tok_d.pending = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q <= wkey;
			val_q <= wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out.act <= 1'b0;
		end else begin
			tok_out <= tok_d;
		end
	end

endmodule
